// File: rtl/bfdh_pkg.sv
// shared types, constants and the modulo step function for the bloom filter core
// no dependencies
package bfdh_pkg;

  localparam int FILTER_BITS = 2097152;
  localparam int MAX_PROBES  = 32;

  localparam int HASH_W = 32;
  localparam int ADDR_W = $clog2(FILTER_BITS);
  localparam int SIZE_W = ADDR_W + 1;

  localparam int CFG_COUNT_W = 6;
  localparam int CFG_SIZE_W  = 22;
  localparam int CFG_DATA_W  = 22;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_PROBE_COUNT = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_SIZE = CFG_INDEX_W'(1);

  localparam logic [CFG_COUNT_W-1:0] PROBE_RESET = CFG_COUNT_W'(11);
  localparam logic [CFG_SIZE_W-1:0]  SIZE_RESET  = CFG_SIZE_W'(2097152);

  localparam int PROBE_W = $clog2(MAX_PROBES + 1);
  localparam logic [PROBE_W-1:0] TWO_HASH_PROBES = PROBE_W'(2);

  localparam int STEP_BITS  = 4;
  localparam int MOD_STAGES = HASH_W / STEP_BITS;

  localparam int ROW_BITS = 32;
  localparam int SEL_W    = $clog2(ROW_BITS);
  localparam int ROW_W    = ADDR_W - SEL_W;
  localparam int ROWS     = 1 << ROW_W;
  localparam logic [ROW_W-1:0] CLR_LAST = ROW_W'(ROWS - 1);

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_CHECK  = 1'b1
  } op_t;

  typedef enum logic {
    FRONT_IDLE,
    FRONT_GEN
  } front_state_t;

  typedef struct packed {
    op_t  op;
    logic last;
  } probe_tag_t;

  typedef struct packed {
    logic [ADDR_W-1:0] idx;
    probe_tag_t        tag;
  } probe_t;

  // restoring remainder over STEP_BITS dividend bits
  function automatic logic [ADDR_W-1:0] mod_step(
    input logic [ADDR_W-1:0]    rem,
    input logic [STEP_BITS-1:0] bits,
    input logic [SIZE_W-1:0]    div
  );
    logic [SIZE_W-1:0] r;
    r = {1'b0, rem};
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      r = {r[ADDR_W-1:0], bits[i]};
      if (r >= div) begin
        r = r - div;
      end
    end
    return r[ADDR_W-1:0];
  endfunction

endpackage

// File: rtl/bloom_filter_double_hash_core.sv
// Bloom filter with double hashing over an on-chip bit store.
// Input channel in_valid/in_stall carries op, first_hash, second_hash; each
// transaction gives exactly one result transaction out_valid/out_stall with found.
// An item occupies the front for an intake step and then n probe issues, n being
// probe_count (capped at 32) or 2 in two-hash mode; the default probe_count is 11.
// Probes go one per cycle while the queue has room through an 8-stage modulo
// pipeline (4 bits a stage), a 4-entry probe queue and the single-port bit store.
// The front takes a new item only after the last probe of the current one issues.
// Insert sets the probe bits and returns found = 0; check returns 1 when all
// probe bits are set.
// Reset clears the store with a sweep over all 65536 rows (one 32-bit row a cycle)
// while in_stall stays high; config writes are taken during the sweep.
// Config: cfg_write with cfg_index 0 (probe_count) or 1 (filter_size), only
// while the block is idle. A stalled result is held in the output register;
// the back end then holds the last probe of the next item, the queue fills and
// the front stops issuing probes until out_stall drops.
// depends on bfdh_pkg, bfdh_front, bfdh_fifo, bfdh_back
module bloom_filter_double_hash_core import bfdh_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   op,
  input  logic [HASH_W-1:0]      first_hash,
  input  logic [HASH_W-1:0]      second_hash,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   found
);

  logic   clearing;
  logic   fifo_full;
  logic   push;
  probe_t push_probe;
  logic   pop;
  probe_t head;
  logic   fifo_valid;

  bfdh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .first_hash  (first_hash),
    .second_hash (second_hash),
    .clearing    (clearing),
    .fifo_full   (fifo_full),
    .push        (push),
    .push_probe  (push_probe)
  );

  bfdh_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_probe),
    .full      (fifo_full),
    .pop       (pop),
    .pop_data  (head),
    .not_empty (fifo_valid)
  );

  bfdh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .fifo_valid (fifo_valid),
    .head       (head),
    .pop        (pop),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found)
  );

endmodule

// File: rtl/bfdh_modpipe.sv
// pipelined 32-bit modulo unit, STEP_BITS dividend bits per stage
// depends on bfdh_pkg
module bfdh_modpipe import bfdh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              in_valid,
  input  probe_tag_t        in_tag,
  input  logic [HASH_W-1:0] dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              out_valid,
  output probe_t            out_probe
);

  logic              stage_valid [MOD_STAGES];
  logic [ADDR_W-1:0] stage_rem   [MOD_STAGES];
  logic [HASH_W-1:0] stage_bits  [MOD_STAGES];
  probe_tag_t        stage_tag   [MOD_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < MOD_STAGES; s++) begin
        stage_valid[s] <= 1'b0;
      end
    end else if (advance) begin
      stage_valid[0] <= in_valid;
      for (int s = 1; s < MOD_STAGES; s++) begin
        stage_valid[s] <= stage_valid[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage_rem[0]  <= mod_step('0, dividend[HASH_W-1 -: STEP_BITS], divisor);
      stage_bits[0] <= dividend << STEP_BITS;
      stage_tag[0]  <= in_tag;
      for (int s = 1; s < MOD_STAGES; s++) begin
        stage_rem[s]  <= mod_step(stage_rem[s-1], stage_bits[s-1][HASH_W-1 -: STEP_BITS],
                                  divisor);
        stage_bits[s] <= stage_bits[s-1] << STEP_BITS;
        stage_tag[s]  <= stage_tag[s-1];
      end
    end
  end

  assign out_valid     = stage_valid[MOD_STAGES-1];
  assign out_probe.idx = stage_rem[MOD_STAGES-1];
  assign out_probe.tag = stage_tag[MOD_STAGES-1];

endmodule

// File: rtl/bfdh_front.sv
// front end: config registers, item intake and probe position generation
// depends on bfdh_pkg and bfdh_modpipe
module bfdh_front import bfdh_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   op,
  input  logic [HASH_W-1:0]      first_hash,
  input  logic [HASH_W-1:0]      second_hash,
  input  logic                   clearing,
  input  logic                   fifo_full,
  output logic                   push,
  output probe_t                 push_probe
);

  logic [CFG_COUNT_W-1:0] probe_count;
  logic [CFG_SIZE_W-1:0]  filter_size;

  front_state_t state;
  front_state_t state_next;

  op_t               op_q;
  logic [HASH_W-1:0] pos;
  logic [HASH_W-1:0] dlt;
  logic [HASH_W-1:0] h2_q;
  logic [PROBE_W-1:0] nprobe;
  logic [PROBE_W-1:0] j;
  logic              two_hash;
  logic [SIZE_W-1:0] size_q;

  logic [PROBE_W-1:0] eff_count;
  logic [SIZE_W-1:0]  eff_size;
  logic               take;
  logic               issue;
  logic               last_probe;
  logic               advance;
  logic               pipe_valid;
  probe_tag_t         issue_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_count <= PROBE_RESET;
      filter_size <= SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PROBE_COUNT: probe_count <= cfg_data[CFG_COUNT_W-1:0];
        REG_FILTER_SIZE: filter_size <= cfg_data[CFG_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(probe_count) > MAX_PROBES) begin
      eff_count = PROBE_W'(MAX_PROBES);
    end else begin
      eff_count = PROBE_W'(probe_count);
    end
    if (filter_size == '0) begin
      eff_size = SIZE_W'(1);
    end else if (int'(filter_size) > FILTER_BITS) begin
      eff_size = SIZE_W'(FILTER_BITS);
    end else begin
      eff_size = SIZE_W'(filter_size);
    end
  end

  assign last_probe = (j == nprobe - PROBE_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FRONT_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    take       = 1'b0;
    issue      = 1'b0;
    case (state)
      FRONT_IDLE: begin
        in_stall = clearing;
        take     = in_valid && !clearing;
        if (take) begin
          state_next = FRONT_GEN;
        end
      end
      FRONT_GEN: begin
        issue = advance;
        if (issue && last_probe) begin
          state_next = FRONT_IDLE;
        end
      end
      default: state_next = FRONT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op_q     <= op_t'(op);
      pos      <= first_hash;
      dlt      <= second_hash + HASH_W'(1);
      h2_q     <= second_hash;
      two_hash <= (eff_count == '0);
      nprobe   <= (eff_count == '0) ? TWO_HASH_PROBES : eff_count;
      j        <= '0;
      size_q   <= eff_size;
    end else if (issue) begin
      pos <= two_hash ? h2_q : pos + dlt;
      dlt <= dlt + HASH_W'(2);
      j   <= j + PROBE_W'(1);
    end
  end

  assign issue_tag.op   = op_q;
  assign issue_tag.last = last_probe;

  assign advance = !pipe_valid || !fifo_full;
  assign push    = pipe_valid && !fifo_full;

  bfdh_modpipe u_modpipe (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (issue),
    .in_tag    (issue_tag),
    .dividend  (pos),
    .divisor   (size_q),
    .out_valid (pipe_valid),
    .out_probe (push_probe)
  );

endmodule

// File: rtl/bfdh_fifo.sv
// short probe queue between front and back
// depends on bfdh_pkg
module bfdh_fifo import bfdh_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  probe_t push_data,
  output logic   full,
  input  logic   pop,
  output probe_t pop_data,
  output logic   not_empty
);

  probe_t           entries [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full      = (count == (PTR_W+1)'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PTR_W+1)'(1);
        2'b01:   count <= count - (PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/bfdh_back.sv
// back end: bit store with clear sweep, probe execution and result register
// depends on bfdh_pkg
module bfdh_back import bfdh_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   fifo_valid,
  input  probe_t head,
  output logic   pop,
  output logic   clearing,
  output logic   out_valid,
  input  logic   out_stall,
  output logic   found
);

  logic [ROW_BITS-1:0] mem [ROWS];

  logic [ROW_W-1:0]    clr_row;
  logic                wr_en;
  logic [ROW_W-1:0]    wr_row;
  logic [ROW_BITS-1:0] wr_mask;
  logic [ROW_BITS-1:0] wr_data;
  logic                rd_en;
  logic [ROW_BITS-1:0] rd_data;

  logic             s1_valid;
  probe_tag_t       s1_tag;
  logic [SEL_W-1:0] s1_sel;
  logic             acc;
  logic             probe_hit;
  logic             all_now;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;
  assign pop      = fifo_valid && !clearing &&
                    (!head.tag.last || (out_free && !(s1_valid && s1_tag.last)));

  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_row  = clr_row;
      wr_mask = '1;
      wr_data = '0;
    end else begin
      wr_en   = pop && (head.tag.op == OP_INSERT);
      wr_row  = head.idx[ADDR_W-1:SEL_W];
      wr_mask = ROW_BITS'(1) << head.idx[SEL_W-1:0];
      wr_data = '1;
    end
  end

  assign rd_en = pop && (head.tag.op == OP_CHECK);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int b = 0; b < ROW_BITS; b++) begin
        if (wr_mask[b]) begin
          mem[wr_row][b] <= wr_data[b];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[head.idx[ADDR_W-1:SEL_W]];
    end
  end

  assign probe_hit = (s1_tag.op == OP_CHECK) ? rd_data[s1_sel] : 1'b1;
  assign all_now   = acc && probe_hit;

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_tag <= head.tag;
      s1_sel <= head.idx[SEL_W-1:0];
    end
    if (s1_valid && s1_tag.last) begin
      found <= (s1_tag.op == OP_CHECK) && all_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_row   <= '0;
      s1_valid  <= 1'b0;
      acc       <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_row <= clr_row + ROW_W'(1);
        if (clr_row == CLR_LAST) begin
          clearing <= 1'b0;
        end
      end
      s1_valid <= pop;
      if (s1_valid) begin
        acc <= s1_tag.last ? 1'b1 : all_now;
      end
      if (s1_valid && s1_tag.last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (rst) clearing |-> !pop)
    else $error("probe taken during clear sweep");
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_tag.last) |-> (!out_valid || !out_stall))
    else $error("result would overwrite a held output");
  assert property (@(posedge clk) disable iff (rst)
    (clearing && clr_row == CLR_LAST) |=> !clearing)
    else $error("clear sweep did not end after last row");
`endif

endmodule
